### rtl/core/kwm_pkg.sv
// kwm_pkg: shared constants for the k-way merge block.
// No dependencies; used by k_way_merge_by_key_top.
package kwm_pkg;

    // op field codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // fixed port field widths
    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int LIST_W = 3;

endpackage

### rtl/core/kwm_ram.sv
// kwm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/kwm_max_sel.sv
// kwm_max_sel: balanced comparator tree, picks the largest valid key.
// Ties go to the lower index. No dependencies.
module kwm_max_sel #(
    parameter int N  = 8,
    parameter int KW = 32
) (
    input  logic [N-1:0]         valid,
    input  logic [KW-1:0]        keys [N],
    output logic                 found,
    output logic [$clog2(N)-1:0] idx,
    output logic [KW-1:0]        key
);

    localparam int IW = $clog2(N);
    localparam int P  = 1 << IW;

    // heap-ordered nodes: 1 is the root, P..2P-1 are the leaves
    logic          node_v [2*P];
    logic [KW-1:0] node_k [2*P];
    logic [IW-1:0] node_i [2*P];

    always_comb
    begin
        node_v[0] = 1'b0;
        node_k[0] = '0;
        node_i[0] = '0;
        for (int n = 0; n < P; n++)
        begin
            node_i[P+n] = IW'(n);
            if (n < N)
            begin
                node_v[P+n] = valid[n];
                node_k[P+n] = keys[n];
            end
            else
            begin
                node_v[P+n] = 1'b0;
                node_k[P+n] = '0;
            end
        end
        for (int n = P - 1; n >= 1; n--)
        begin
            // left child holds the lower indices, so it wins ties
            if (node_v[2*n] && (!node_v[2*n+1] || node_k[2*n] >= node_k[2*n+1]))
            begin
                node_v[n] = 1'b1;
                node_k[n] = node_k[2*n];
                node_i[n] = node_i[2*n];
            end
            else
            begin
                node_v[n] = node_v[2*n+1];
                node_k[n] = node_k[2*n+1];
                node_i[n] = node_i[2*n+1];
            end
        end
    end

    assign found = node_v[1];
    assign idx   = node_i[1];
    assign key   = node_k[1];

endmodule

### rtl/core/k_way_merge_by_key_top.sv
// k_way_merge_by_key_top: k-way merge of per-list FIFOs, takes the largest head.
// Uses kwm_pkg, kwm_ram (list storage) and kwm_max_sel (head compare tree).
//
//  channel  | dir | handshake                   | word fields
//  ---------+-----+-----------------------------+---------------------------------------
//  item     | in  | item_valid / item_stall     | op, list_index, item_key, item_tag
//  result   | out | result_valid / result_stall | out_key, out_tag, out_list,
//           |     |                             | all_empty, overflow_seen
//
// One word per cycle while item_stall is low: heads sit in registers and the compare
// tree picks the max in the cycle the take arrives; the popped list's next head is read
// from the list RAM and used straight from its read register in the following cycle.
// A take's result is registered, valid in the cycle after acceptance; loads give none.
// item_stall is high only while a result is held and result_stall is high.
// Reset clears the fill counts, read positions and overflow flag; no clear pass.
module k_way_merge_by_key_top #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 16,
    parameter int KEY_BITS   = 32,
    parameter int TAG_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         op,
    input  logic [kwm_pkg::LIST_W-1:0]   list_index,
    input  logic [kwm_pkg::KEY_W-1:0]    item_key,
    input  logic [kwm_pkg::TAG_W-1:0]    item_tag,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [kwm_pkg::KEY_W-1:0]    out_key,
    output logic [kwm_pkg::TAG_W-1:0]    out_tag,
    output logic [kwm_pkg::LIST_W-1:0]   out_list,
    output logic                         all_empty,
    output logic                         overflow_seen
);

    localparam int LW = $clog2(NUM_LISTS);
    localparam int DW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = KEY_BITS + TAG_BITS;
    localparam int RAM_DEPTH = NUM_LISTS << DW;

    // per-list control
    logic [DW-1:0]       rp_reg [NUM_LISTS];
    logic [CW-1:0]       fc_reg [NUM_LISTS];
    logic [KEY_BITS-1:0] head_key_reg [NUM_LISTS];
    logic [TAG_BITS-1:0] head_tag_reg [NUM_LISTS];
    logic                ovf_reg;

    // next head of pend_list_reg is in the RAM read register this cycle
    logic          pend_reg;
    logic [LW-1:0] pend_list_reg;

    logic [EW-1:0]       rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [TAG_BITS-1:0] rd_tag;

    logic [KEY_BITS-1:0] eff_key [NUM_LISTS];
    logic [NUM_LISTS-1:0] head_valid;

    logic                found;
    logic [LW-1:0]       best;
    logic [KEY_BITS-1:0] best_key;
    logic [TAG_BITS-1:0] best_tag;

    logic          item_acc, take_acc, pop, re;
    logic          in_range, load_ok, load_ovf;
    logic [LW-1:0] li;
    logic [SW-1:0] slot_sum, slot;
    logic [DW-1:0] rp_inc;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [kwm_pkg::KEY_W-1:0]  out_key_reg;
    logic [kwm_pkg::TAG_W-1:0]  out_tag_reg;
    logic [kwm_pkg::LIST_W-1:0] out_list_reg;
    logic                       all_empty_reg;
    logic                       ovf_seen_reg;

    assign rd_key = rd_data[EW-1:TAG_BITS];
    assign rd_tag = rd_data[TAG_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            head_valid[i] = (fc_reg[i] != '0);
            if (pend_reg && pend_list_reg == LW'(i))
            begin
                eff_key[i] = rd_key;
            end
            else
            begin
                eff_key[i] = head_key_reg[i];
            end
        end
    end

    kwm_max_sel #(
        .N  (NUM_LISTS),
        .KW (KEY_BITS)
    ) u_sel (
        .valid (head_valid),
        .keys  (eff_key),
        .found (found),
        .idx   (best),
        .key   (best_key)
    );

    assign best_tag = (pend_reg && pend_list_reg == best) ? rd_tag : head_tag_reg[best];

    assign item_stall = out_valid_reg && result_stall;
    assign item_acc   = item_valid && !item_stall;
    assign take_acc   = item_acc && (op == kwm_pkg::OP_TAKE);
    assign pop        = take_acc && found;
    assign re         = pop && (fc_reg[best] > CW'(1));
    assign rp_inc     = (rp_reg[best] == DW'(LIST_DEPTH - 1)) ? '0 : rp_reg[best] + 1'b1;

    assign in_range = (32'(list_index) < NUM_LISTS);
    assign li       = LW'(list_index);
    assign load_ok  = item_acc && (op == kwm_pkg::OP_LOAD) && in_range
                      && (fc_reg[li] != CW'(LIST_DEPTH));
    assign load_ovf = item_acc && (op == kwm_pkg::OP_LOAD) && in_range
                      && (fc_reg[li] == CW'(LIST_DEPTH));

    // back slot = (rp + fc) mod depth, sum stays below twice the depth
    assign slot_sum = SW'(rp_reg[li]) + SW'(fc_reg[li]);
    assign slot     = (slot_sum >= SW'(LIST_DEPTH)) ? slot_sum - SW'(LIST_DEPTH) : slot_sum;

    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_ok),
        .waddr ({li, slot[DW-1:0]}),
        .wdata ({KEY_BITS'(item_key), TAG_BITS'(item_tag)}),
        .re    (re),
        .raddr ({best, rp_inc}),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                rp_reg[i] <= '0;
                fc_reg[i] <= '0;
            end
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_list_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                rp_reg[best] <= rp_inc;
                fc_reg[best] <= fc_reg[best] - 1'b1;
            end
            if (load_ok)
            begin
                fc_reg[li] <= fc_reg[li] + 1'b1;
            end
            if (load_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            pend_reg      <= re;
            pend_list_reg <= best;
        end
    end

    // head registers: refill from RAM after a pop, direct write into an empty list
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            head_key_reg[pend_list_reg] <= rd_key;
            head_tag_reg[pend_list_reg] <= rd_tag;
        end
        if (load_ok && fc_reg[li] == '0)
        begin
            head_key_reg[li] <= KEY_BITS'(item_key);
            head_tag_reg[li] <= TAG_BITS'(item_tag);
        end
    end

    assign out_valid_next = take_acc || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_acc)
        begin
            out_key_reg   <= found ? kwm_pkg::KEY_W'(best_key) : '0;
            out_tag_reg   <= found ? kwm_pkg::TAG_W'(best_tag) : '0;
            out_list_reg  <= found ? kwm_pkg::LIST_W'(best) : '0;
            all_empty_reg <= !found;
            ovf_seen_reg  <= ovf_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign out_key       = out_key_reg;
    assign out_tag       = out_tag_reg;
    assign out_list      = out_list_reg;
    assign all_empty     = all_empty_reg;
    assign overflow_seen = ovf_seen_reg;

    // refill read only follows a pop
    a_pend_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(pop))
        else $error("head refill without a preceding pop");

    // a pop always hits a non-empty list
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fc_reg[best] != '0)
        else $error("pop from an empty list");

    // an accepted take always yields a result word next cycle
    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_acc |=> out_valid_reg)
        else $error("take accepted without a result");

    // overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

endmodule

### bench/tb_k_way_merge_by_key_top.sv
// Testbench for k_way_merge_by_key_top: directed and random load/take traffic,
// with random gaps on both channels. Each result is checked against a queue-based model.
// Depends on kwm_pkg and the k_way_merge_by_key_top RTL only.
module tb_k_way_merge_by_key_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_W = kwm_pkg::LIST_W;
    localparam int KEY_W  = kwm_pkg::KEY_W;
    localparam int TAG_W  = kwm_pkg::TAG_W;

    localparam int NUM_LISTS   = 8;
    localparam int LIST_DEPTH  = 16;
    localparam int WORD_TARGET = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAUSE = 8;

    typedef struct packed {
        logic              op;
        logic [LIST_W-1:0] list;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
    } merge_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } list_elem_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic [LIST_W-1:0] list;
        logic              empty;
        logic              ovf;
    } merge_out_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic              op           = kwm_pkg::OP_LOAD;
    logic [LIST_W-1:0] list_index   = '0;
    logic [KEY_W-1:0]  item_key     = '0;
    logic [TAG_W-1:0]  item_tag     = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [KEY_W-1:0]  out_key;
    logic [TAG_W-1:0]  out_tag;
    logic [LIST_W-1:0] out_list;
    logic              all_empty;
    logic              overflow_seen;

    // model state: one queue per list plus the sticky overflow bit
    list_elem_t  lane_fifo [NUM_LISTS][$];
    logic        overflow_pred = 1'b0;
    merge_out_t  merged_due[$];
    merge_word_t pending_words[$];

    int   total_words     = 0;
    int   words_sent      = 0;
    int   results_checked = 0;
    int   empty_results   = 0;
    int   overflow_results = 0;
    int   err_count       = 0;
    int   cycle_count     = 0;
    int   send_gap        = 0;
    int   send_calm       = 0;
    int   hold_left       = 0;
    int   recv_calm       = 0;
    logic word_sent       = 1'b0;
    merge_word_t next_word;
    merge_out_t  due;

    k_way_merge_by_key_top #(
        .NUM_LISTS (NUM_LISTS),
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .list_index   (list_index),
        .item_key     (item_key),
        .item_tag     (item_tag),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_key      (out_key),
        .out_tag      (out_tag),
        .out_list     (out_list),
        .all_empty    (all_empty),
        .overflow_seen(overflow_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle cycles before the next word; now and then a run with no idling at all
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0: return KEY_W'($urandom_range(0, 3));        // dense, makes ties likely
            1: return {16'($urandom_range(0, 7)), 16'h0};  // whole numbers
            2: return $urandom_range(0, 1) ? '1 : '0;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic queue_word(input merge_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic queue_load(input int lst, input logic [KEY_W-1:0] k,
                              input logic [TAG_W-1:0] t);
        queue_word('{kwm_pkg::OP_LOAD, LIST_W'(lst), k, t});
    endtask

    task automatic queue_take();
        // list, key and tag are don't-care on a take; keep them busy anyway
        queue_word('{kwm_pkg::OP_TAKE, LIST_W'($urandom), KEY_W'($urandom),
                     TAG_W'($urandom)});
    endtask

    // model of the merge: loads append, a take pops the largest head
    task automatic merge_apply_word(input merge_word_t w);
        merge_out_t r;
        list_elem_t head;
        list_elem_t elem;
        int best;
        if (w.op == kwm_pkg::OP_LOAD)
        begin
            if (int'(w.list) >= NUM_LISTS)
                return;
            if (lane_fifo[w.list].size() >= LIST_DEPTH)
                overflow_pred = 1'b1;
            else
            begin
                elem.key = w.key;
                elem.tag = w.tag;
                lane_fifo[w.list].insert(lane_fifo[w.list].size(), elem);
            end
            return;
        end
        best = -1;
        for (int i = 0; i < NUM_LISTS; i++)
            if (lane_fifo[i].size() != 0 &&
                (best < 0 || lane_fifo[i][0].key > lane_fifo[best][0].key))
                best = i;
        r = '0;
        if (best < 0)
            r.empty = 1'b1;
        else
        begin
            head   = lane_fifo[best].pop_front();
            r.key  = head.key;
            r.tag  = head.tag;
            r.list = LIST_W'(best);
        end
        r.ovf = overflow_pred;
        merged_due.insert(merged_due.size(), r);
    endtask

    task automatic report_fault(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    // driver: words change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !word_sent)
            begin
                // stalled, hold the word
            end
            else if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_words.size() != 0)
            begin
                next_word   = pending_words.pop_front();
                op         <= next_word.op;
                list_index <= next_word.list;
                item_key   <= next_word.key;
                item_tag   <= next_word.tag;
                item_valid <= 1'b1;
                send_gap    = draw_gap(send_calm);
            end
            else
                item_valid <= 1'b0;
            word_sent = 1'b0;

            result_stall <= (hold_left > 0);
            if (hold_left > 0)
                hold_left--;
        end
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (item_valid && !item_stall)
            begin
                word_sent = 1'b1;
                words_sent++;
                merge_apply_word('{op, list_index, item_key, item_tag});
            end
            if (result_valid && !result_stall)
            begin
                hold_left = draw_gap(recv_calm);
                results_checked++;
                if (merged_due.size() == 0)
                    report_fault($sformatf(
                        "result with none due: key=%h tag=%h list=%0d empty=%b ovf=%b",
                        out_key, out_tag, out_list, all_empty, overflow_seen));
                else
                begin
                    due = merged_due.pop_front();
                    if (due.empty)
                        empty_results++;
                    if (due.ovf)
                        overflow_results++;
                    if (out_key !== due.key || out_tag !== due.tag ||
                        out_list !== due.list || all_empty !== due.empty ||
                        overflow_seen !== due.ovf)
                        report_fault($sformatf({"exp key=%h tag=%h list=%0d empty=%b ovf=%b",
                            " | got key=%h tag=%h list=%0d empty=%b ovf=%b"},
                            due.key, due.tag, due.list, due.empty, due.ovf,
                            out_key, out_tag, out_list, all_empty, overflow_seen));
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, merged_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int  pick;
        int  lst;
        int  n;
        logic overflow_done;

        overflow_done = 1'b0;

        // directed: take on empty lists, key extremes, ties, unsorted list, drain
        queue_take();
        queue_load(0, 32'h0000_0000, 16'h0000);
        queue_load(7, 32'hFFFF_FFFF, 16'hFFFF);
        queue_load(3, 32'h0001_0000, 16'h1234);
        queue_load(5, 32'h0001_0000, 16'h5678);
        queue_load(1, 32'h0001_0000, 16'hAAAA);
        queue_load(3, 32'hFFFF_FFFF, 16'h5555);
        queue_load(6, 32'h0000_0005, 16'h0F0F);
        queue_load(6, 32'h0000_0009, 16'hF0F0);
        queue_load(2, 32'h8000_0000, 16'h8001);
        queue_load(4, 32'h7FFF_FFFF, 16'h7FFE);
        repeat (11) queue_take();

        while (pending_words.size() < WORD_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (!overflow_done && pending_words.size() > WORD_TARGET / 2)
            begin
                // push one list past full
                lst = $urandom_range(0, NUM_LISTS - 1);
                repeat (LIST_DEPTH + 2) queue_load(lst, pick_key(), TAG_W'($urandom));
                overflow_done = 1'b1;
            end
            else if (pick < 6)
            begin
                n = $urandom_range(10, 30);
                repeat (n)
                    if ($urandom_range(0, 99) < 45)
                        queue_take();
                    else
                        queue_load($urandom_range(0, NUM_LISTS - 1), pick_key(),
                                   TAG_W'($urandom));
            end
            else if (pick < 8)
            begin
                lst = $urandom_range(0, NUM_LISTS - 1);
                n = $urandom_range(2, 12);
                repeat (n) queue_load(lst, pick_key(), TAG_W'($urandom));
            end
            else
            begin
                n = $urandom_range(3, 20);
                repeat (n) queue_take();
            end
        end
        total_words = pending_words.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (words_sent == total_words);
        while (merged_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);

        $display("sent %0d words, checked %0d merged results",
                 words_sent, results_checked);
        $display("(%0d from empty lists, %0d after overflow), mismatches: %0d",
                 empty_results, overflow_results, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
